/* src/bcq_pkg.sv */
`default_nettype none

package bcq_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_MS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MS       = 3'd4;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned TIME_W     = 32;

	// Input request kinds
	localparam logic OP_POLL   = 1'b0;
	localparam logic OP_CANCEL = 1'b1;

	// Stream widths: input tdata holds raw_level and now_ms, output tdata the result
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 16;

	// Result flags, pushed in the lowest bit
	typedef struct packed {
		logic is_off;
		logic is_on;
		logic repeat_event;
		logic long_press;
		logic second_push;
		logic double_click;
		logic single_click;
		logic released;
		logic pushed;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

/* src/button_click_qualifier_core.sv */
`default_nettype none

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: opcode; tdata: raw_level, now_ms
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: pushed .. is_off
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One result per request. A request is held in the input register and
// is evaluated against the qualifier state on the way into the output register,
// so a new request is taken every cycle while results are drained.
// The output register stalls the input register only when it is full and not taken.
// arst_n clears the qualifier state and loads the register defaults.

module button_click_qualifier_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// s_axis
	input  wire logic                                s_axis_tvalid,
	output      logic                                s_axis_tready,
	input  wire logic [bcq_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [0] raw_level, [32:1] now_ms
	input  wire logic                                s_axis_tuser,  // [0] opcode
	// m_axis
	output      logic                                m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output      logic [bcq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [0] pushed, [1] released,
	                                                                 // [2] single_click,
	                                                                 // [3] double_click,
	                                                                 // [4] second_push,
	                                                                 // [5] long_press,
	                                                                 // [6] repeat_event,
	                                                                 // [7] is_on, [8] is_off
	// configuration
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [bcq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [bcq_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int unsigned TW = bcq_pkg::TIME_W;
	localparam int unsigned CW = bcq_pkg::CFG_DATA_W;

	// Configuration registers
	logic          active_level_q;
	logic [CW-1:0] debounce_ms_q;
	logic [CW-1:0] double_click_ms_q;
	logic [CW-1:0] long_press_ms_q;
	logic [CW-1:0] repeat_ms_q;

	// Input stage
	logic          valid_s1;
	logic          opcode_s1;
	logic          raw_s1;
	logic [TW-1:0] now_s1;

	// Qualifier state
	logic          level_on_q, level_off_q, prev_on_q, in_debounce_q;
	logic [TW-1:0] debounce_start_q;
	logic          click_pending_q, click_releasing_q, double_pending_q;
	logic [TW-1:0] click_start_q;
	logic          long_holding_q;
	logic [TW-1:0] repeat_start_q;

	// Output register
	logic              out_valid_q;
	bcq_pkg::result_t  result_q;

	// Next state
	logic          level_on_d, level_off_d, prev_on_d, in_debounce_d;
	logic [TW-1:0] debounce_start_d;
	logic          click_pending_d, click_releasing_d, double_pending_d;
	logic [TW-1:0] click_start_d;
	logic          long_holding_d;
	logic [TW-1:0] repeat_start_d;
	bcq_pkg::result_t result_d;

	logic advance;
	logic fire;

	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(bcq_pkg::OUT_DATA_W - bcq_pkg::RESULT_W){1'b0}}, result_q};

	// Evaluate one request against the held state
	always_comb begin
		logic poll;
		logic sample;
		logic lvl;
		logic edge_seen;
		logic [TW-1:0] deb_diff;
		logic [TW-1:0] dcl_diff;
		logic [TW-1:0] lng_diff;
		logic [TW-1:0] rep_diff;

		level_on_d        = level_on_q;
		level_off_d       = level_off_q;
		prev_on_d         = prev_on_q;
		in_debounce_d     = in_debounce_q;
		debounce_start_d  = debounce_start_q;
		click_pending_d   = click_pending_q;
		click_releasing_d = click_releasing_q;
		double_pending_d  = double_pending_q;
		click_start_d     = click_start_q;
		long_holding_d    = long_holding_q;
		repeat_start_d    = repeat_start_q;
		result_d          = '0;

		poll   = (opcode_s1 == bcq_pkg::OP_POLL);
		sample = poll && !in_debounce_q;
		lvl    = raw_s1 ^ !active_level_q;

		// Sample the level and find edges
		deb_diff = now_s1 - debounce_start_q;
		if (sample) begin
			level_on_d  = lvl;
			level_off_d = !lvl;
		end
		result_d.pushed   = sample && lvl && !prev_on_q;
		result_d.released = sample && !lvl && prev_on_q;
		edge_seen         = result_d.pushed || result_d.released;

		// Hold off sampling after an edge
		if (poll) begin
			if (in_debounce_q) begin
				if (deb_diff > {{(TW-CW){1'b0}}, debounce_ms_q})
					in_debounce_d = 1'b0;
			end else if (edge_seen) begin
				in_debounce_d    = 1'b1;
				debounce_start_d = now_s1;
			end
		end

		// Click sequence
		if (result_d.pushed && click_releasing_d) begin
			double_pending_d     = 1'b1;
			click_releasing_d    = 1'b0;
			result_d.second_push = 1'b1;
		end
		if (result_d.released && double_pending_d) begin
			double_pending_d      = 1'b0;
			result_d.double_click = 1'b1;
		end
		if (result_d.pushed && !click_pending_d && !double_pending_d) begin
			click_start_d   = now_s1;
			click_pending_d = 1'b1;
		end
		if (result_d.released && click_pending_d) begin
			click_releasing_d = 1'b1;
			click_pending_d   = 1'b0;
		end
		dcl_diff = now_s1 - click_start_d;
		if (sample && click_releasing_d &&
		    dcl_diff > {{(TW-CW){1'b0}}, double_click_ms_q}) begin
			click_releasing_d     = 1'b0;
			result_d.single_click = 1'b1;
		end

		// Drop a pending single click on cancel
		if (!poll)
			click_pending_d = 1'b0;

		// Long press and auto-repeat on the retained level
		lng_diff = now_s1 - click_start_d;
		if (result_d.pushed)
			repeat_start_d = now_s1;
		rep_diff = now_s1 - repeat_start_d;
		if (poll) begin
			if (level_on_d && lng_diff > {{(TW-CW){1'b0}}, long_press_ms_q} &&
			    !long_holding_q) begin
				long_holding_d      = 1'b1;
				result_d.long_press = 1'b1;
				click_pending_d     = 1'b0;
				double_pending_d    = 1'b0;
			end
			if (level_off_d)
				long_holding_d = 1'b0;
			result_d.repeat_event = result_d.pushed;
			if (level_on_d && rep_diff > {{(TW-CW){1'b0}}, repeat_ms_q}) begin
				repeat_start_d        = now_s1;
				result_d.repeat_event = 1'b1;
			end
			prev_on_d = level_on_d;
		end

		result_d.is_on  = level_on_d;
		result_d.is_off = level_off_d;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q    <= 1'b1;
			debounce_ms_q     <= CW'(20);
			double_click_ms_q <= CW'(300);
			long_press_ms_q   <= CW'(1000);
			repeat_ms_q       <= CW'(200);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bcq_pkg::REG_ACTIVE_LEVEL:    active_level_q    <= cfg_data[0];
				bcq_pkg::REG_DEBOUNCE_MS:     debounce_ms_q     <= cfg_data;
				bcq_pkg::REG_DOUBLE_CLICK_MS: double_click_ms_q <= cfg_data;
				bcq_pkg::REG_LONG_PRESS_MS:   long_press_ms_q   <= cfg_data;
				bcq_pkg::REG_REPEAT_MS:       repeat_ms_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1 <= s_axis_tuser;
			raw_s1    <= s_axis_tdata[0];
			now_s1    <= s_axis_tdata[TW:1];
		end
	end

	// Qualifier state, advanced once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_on_q        <= 1'b0;
			level_off_q       <= 1'b0;
			prev_on_q         <= 1'b0;
			in_debounce_q     <= 1'b0;
			debounce_start_q  <= '0;
			click_pending_q   <= 1'b0;
			click_releasing_q <= 1'b0;
			double_pending_q  <= 1'b0;
			click_start_q     <= '0;
			long_holding_q    <= 1'b0;
			repeat_start_q    <= '0;
		end else if (fire) begin
			level_on_q        <= level_on_d;
			level_off_q       <= level_off_d;
			prev_on_q         <= prev_on_d;
			in_debounce_q     <= in_debounce_d;
			debounce_start_q  <= debounce_start_d;
			click_pending_q   <= click_pending_d;
			click_releasing_q <= click_releasing_d;
			double_pending_q  <= double_pending_d;
			click_start_q     <= click_start_d;
			long_holding_q    <= long_holding_d;
			repeat_start_q    <= repeat_start_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			result_q <= result_d;
	end

endmodule

`default_nettype wire
